// ===== hw/rtl/mandelbrot_iteration_step_assert.svh =====
// assertion macros for the iteration step pipeline
`ifndef MANDELBROT_ITERATION_STEP_ASSERT_SVH
`define MANDELBROT_ITERATION_STEP_ASSERT_SVH

// same-cycle implication, sampled on clk, idle in reset
`define MIB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, idle in reset
`define MIB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mib_pkg.sv =====
// types, constants and sign-magnitude add for the iteration step
package mib_pkg;

    localparam int DIGITS       = 4;
    localparam int GUARD_DIGITS = 2;
    localparam int DIGIT_BITS   = 32;
    localparam int LAST_COL     = DIGITS + GUARD_DIGITS - 1;
    localparam int NUM_COLS     = LAST_COL + 1;
    localparam int MAG_W        = DIGITS * DIGIT_BITS;
    localparam int HALF_W       = MAG_W / 2;
    localparam int PROD_W       = 2 * DIGIT_BITS;
    localparam int COL_W        = PROD_W + 3;
    localparam int SUM_W        = DIGIT_BITS * NUM_COLS;
    localparam int CFG_IDX_W    = 3;
    localparam int STAGES       = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL_NEGATIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL_HIGH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_C_REAL_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG_NEGATIVE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG_LOW      = 3'd5;

    typedef struct packed {
        logic              neg;
        logic [MAG_W-1:0]  mag;
    } fx_t;

    typedef struct packed {
        logic              z_real_negative;
        logic [HALF_W-1:0] z_real_high;
        logic [HALF_W-1:0] z_real_low;
        logic              z_imag_negative;
        logic [HALF_W-1:0] z_imag_high;
        logic [HALF_W-1:0] z_imag_low;
    } in_t;

    typedef struct packed {
        logic              next_real_negative;
        logic [HALF_W-1:0] next_real_high;
        logic [HALF_W-1:0] next_real_low;
        logic              next_imag_negative;
        logic [HALF_W-1:0] next_imag_high;
        logic [HALF_W-1:0] next_imag_low;
    } out_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } mul_en_t;

    // mixed signs: larger magnitude wins, equal gives +0
    function automatic fx_t fx_add(input fx_t a, input fx_t b);
        fx_t r;
        r.neg = 1'b0;
        r.mag = '0;
        if (a.neg == b.neg) begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end else if (a.mag > b.mag) begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end else if (a.mag < b.mag) begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/mandelbrot_iteration_step.sv =====
// top level: Zn = Z*Z + C, five-stage pipeline with config registers
//
//  channel | signals                      | direction
//  in      | in_valid, in_stall, in_data  | Z in, stall out
//  out     | out_valid, out_stall, out_data | Zn out, stall in
//  cfg     | cfg_we, cfg_index, cfg_data  | register write in
//
// one item per cycle sustained while out_stall is low; out_valid is the valid bit of the last
// stage, and the output transfers while out_valid is high and out_stall is low
// stages: products, column sums, assembly, Z*Z difference and doubling, add C
// reset clears the config registers to zero and empties the pipeline
// out_stall holds the last stage and the unbroken run of full stages behind it; other stages still fill gaps

`include "mandelbrot_iteration_step_assert.svh"

module mandelbrot_iteration_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  mib_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output mib_pkg::out_t                  out_data,
    input  logic                           cfg_we,
    input  logic [mib_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mib_pkg::HALF_W-1:0]     cfg_data
);

    logic [mib_pkg::STAGES-1:0] vld_reg;
    logic [mib_pkg::STAGES-1:0] en;
    mib_pkg::mul_en_t           mul_en;

    logic                       cr_neg_reg;
    logic [mib_pkg::MAG_W-1:0]  cr_mag_reg;
    logic                       ci_neg_reg;
    logic [mib_pkg::MAG_W-1:0]  ci_mag_reg;

    mib_pkg::fx_t zr;
    mib_pkg::fx_t zi;
    mib_pkg::fx_t cr;
    mib_pkg::fx_t ci;
    mib_pkg::fx_t rr;
    mib_pkg::fx_t ii;
    mib_pkg::fx_t ri;
    mib_pkg::fx_t ii_neg;
    mib_pkg::fx_t re4_next;
    mib_pkg::fx_t im4_next;
    mib_pkg::fx_t re4_reg;
    mib_pkg::fx_t im4_reg;
    mib_pkg::fx_t re5_next;
    mib_pkg::fx_t im5_next;
    mib_pkg::fx_t re5_reg;
    mib_pkg::fx_t im5_reg;

    // stage enables: a stage moves when empty or when the next one moves
    always_comb
    begin
        en[mib_pkg::STAGES-1] = !vld_reg[mib_pkg::STAGES-1] || !out_stall;
        for (int k = mib_pkg::STAGES - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign in_stall  = !en[0];
    assign mul_en.s1 = en[0];
    assign mul_en.s2 = en[1];
    assign mul_en.s3 = en[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < mib_pkg::STAGES; k++)
            begin
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_neg_reg <= 1'b0;
            cr_mag_reg <= '0;
            ci_neg_reg <= 1'b0;
            ci_mag_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mib_pkg::CFG_C_REAL_NEGATIVE: cr_neg_reg <= cfg_data[0];
                mib_pkg::CFG_C_REAL_HIGH:
                    cr_mag_reg[mib_pkg::MAG_W-1 -: mib_pkg::HALF_W] <= cfg_data;
                mib_pkg::CFG_C_REAL_LOW:
                    cr_mag_reg[mib_pkg::HALF_W-1:0] <= cfg_data;
                mib_pkg::CFG_C_IMAG_NEGATIVE: ci_neg_reg <= cfg_data[0];
                mib_pkg::CFG_C_IMAG_HIGH:
                    ci_mag_reg[mib_pkg::MAG_W-1 -: mib_pkg::HALF_W] <= cfg_data;
                mib_pkg::CFG_C_IMAG_LOW:
                    ci_mag_reg[mib_pkg::HALF_W-1:0] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign zr.neg = in_data.z_real_negative;
    assign zr.mag = {in_data.z_real_high, in_data.z_real_low};
    assign zi.neg = in_data.z_imag_negative;
    assign zi.mag = {in_data.z_imag_high, in_data.z_imag_low};
    assign cr.neg = cr_neg_reg;
    assign cr.mag = cr_mag_reg;
    assign ci.neg = ci_neg_reg;
    assign ci.mag = ci_mag_reg;

    mib_mul u_mul_rr (.clk(clk), .en(mul_en), .a(zr), .b(zr), .p(rr));
    mib_mul u_mul_ii (.clk(clk), .en(mul_en), .a(zi), .b(zi), .p(ii));
    mib_mul u_mul_ri (.clk(clk), .en(mul_en), .a(zr), .b(zi), .p(ri));

    // stage 4: Zr^2 - Zi^2, and 2*Zr*Zi
    always_comb
    begin
        ii_neg.neg   = 1'b1;
        ii_neg.mag   = ii.mag;
        re4_next     = mib_pkg::fx_add(rr, ii_neg);
        im4_next.neg = ri.neg;
        im4_next.mag = {ri.mag[mib_pkg::MAG_W-2:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            re4_reg <= re4_next;
            im4_reg <= im4_next;
        end
    end

    // stage 5: add C
    assign re5_next = mib_pkg::fx_add(re4_reg, cr);
    assign im5_next = mib_pkg::fx_add(im4_reg, ci);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            re5_reg <= re5_next;
            im5_reg <= im5_next;
        end
    end

    assign out_valid                   = vld_reg[mib_pkg::STAGES-1];
    assign out_data.next_real_negative = re5_reg.neg;
    assign out_data.next_real_high     = re5_reg.mag[mib_pkg::MAG_W-1 -: mib_pkg::HALF_W];
    assign out_data.next_real_low      = re5_reg.mag[mib_pkg::HALF_W-1:0];
    assign out_data.next_imag_negative = im5_reg.neg;
    assign out_data.next_imag_high     = im5_reg.mag[mib_pkg::MAG_W-1 -: mib_pkg::HALF_W];
    assign out_data.next_imag_low      = im5_reg.mag[mib_pkg::HALF_W-1:0];

    `MIB_ASSERT_NOW(a_empty_first_stage_takes, !vld_reg[0], !in_stall, "empty stage stalls input")
    `MIB_ASSERT_NEXT(a_transfer_enters, in_valid && !in_stall, vld_reg[0], "transfer lost at entry")
    `MIB_ASSERT_NOW(a_full_stalled_blocks, (&vld_reg) && out_stall, in_stall, "full pipe accepts")

endmodule

// ===== hw/rtl/mib_mul.sv =====
// three-stage truncated digit product: partial products, column sums, assembly
module mib_mul (
    input  logic             clk,
    input  mib_pkg::mul_en_t en,
    input  mib_pkg::fx_t     a,
    input  mib_pkg::fx_t     b,
    output mib_pkg::fx_t     p
);

    logic [mib_pkg::PROD_W-1:0] prod_reg [mib_pkg::DIGITS][mib_pkg::DIGITS];
    logic [mib_pkg::COL_W-1:0]  col_next [mib_pkg::NUM_COLS];
    logic [mib_pkg::COL_W-1:0]  col_reg  [mib_pkg::NUM_COLS];
    logic [mib_pkg::SUM_W-1:0]  sum_next;
    logic                       neg1_reg;
    logic                       neg2_reg;
    mib_pkg::fx_t               p_reg;

    // stage 1: one 32x32 product per digit pair inside the kept columns
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            neg1_reg <= a.neg ^ b.neg;
            for (int i = 0; i < mib_pkg::DIGITS; i++)
            begin
                for (int j = 0; j < mib_pkg::DIGITS; j++)
                begin
                    if (i + j <= mib_pkg::LAST_COL)
                        prod_reg[i][j] <=
                            a.mag[mib_pkg::MAG_W-1-mib_pkg::DIGIT_BITS*i -: mib_pkg::DIGIT_BITS]
                          * b.mag[mib_pkg::MAG_W-1-mib_pkg::DIGIT_BITS*j -: mib_pkg::DIGIT_BITS];
                    else
                        prod_reg[i][j] <= '0;
                end
            end
        end
    end

    // stage 2: sum of products per column
    always_comb
    begin
        for (int k = 0; k < mib_pkg::NUM_COLS; k++)
        begin
            col_next[k] = '0;
            for (int i = 0; i < mib_pkg::DIGITS; i++)
            begin
                for (int j = 0; j < mib_pkg::DIGITS; j++)
                begin
                    if (i + j == k)
                        col_next[k] = col_next[k] + mib_pkg::COL_W'(prod_reg[i][j]);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            neg2_reg <= neg1_reg;
            col_reg  <= col_next;
        end
    end

    // stage 3: weighted column add, carries past the integer digit wrap
    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < mib_pkg::NUM_COLS; k++)
            sum_next = sum_next + (mib_pkg::SUM_W'(col_reg[k])
                << (mib_pkg::DIGIT_BITS * (mib_pkg::LAST_COL - k)));
    end

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            p_reg.neg <= neg2_reg;
            p_reg.mag <= sum_next[mib_pkg::SUM_W-1 -: mib_pkg::MAG_W];
        end
    end

    assign p = p_reg;

endmodule

// ===== test/mandelbrot_iteration_step_test.sv =====
// testbench for the mandelbrot iteration step: directed table then random Z, predicted results
`timescale 1ns / 1ps

module mandelbrot_iteration_step_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        mib_pkg::in_t  z;
        bit            known;
        mib_pkg::out_t res;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    mib_pkg::in_t  in_data;
    logic out_valid;
    logic out_stall;
    mib_pkg::out_t out_data;
    logic cfg_we;
    logic [mib_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [mib_pkg::HALF_W-1:0] cfg_data;

    mib_pkg::fx_t  c_real;
    mib_pkg::fx_t  c_imag;
    mib_pkg::out_t next_z_q[$];
    row_t dir_rows[$];
    int   errors;
    int   cycles;
    int   burst_left;
    int   hold_reqs;
    int   holds_seen;
    int   hold_left;

    mandelbrot_iteration_step u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic logic [31:0] digit(input mib_pkg::fx_t a, input int i);
        return a.mag[mib_pkg::MAG_W-1-mib_pkg::DIGIT_BITS*i -: mib_pkg::DIGIT_BITS];
    endfunction

    // column sums up to the last guard column, carries ripple toward the integer digit
    function automatic mib_pkg::fx_t mul_trunc(input mib_pkg::fx_t a, input mib_pkg::fx_t b);
        mib_pkg::fx_t r;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] p;
        logic [63:0] t;
        r.neg = a.neg ^ b.neg;
        r.mag = '0;
        lo = '0;
        hi = '0;
        for (int s = mib_pkg::LAST_COL; s >= 0; s--)
        begin
            for (int i = 0; i <= s; i++)
            begin
                if (i < mib_pkg::DIGITS && s - i < mib_pkg::DIGITS)
                begin
                    p = 64'(digit(a, i)) * 64'(digit(b, s - i));
                    lo += {32'b0, p[31:0]};
                    hi += {32'b0, p[63:32]};
                end
            end
            if (s < mib_pkg::DIGITS)
                r.mag[mib_pkg::MAG_W-1-mib_pkg::DIGIT_BITS*s -: mib_pkg::DIGIT_BITS] = lo[31:0];
            t = hi + (lo >> 32);
            lo = {32'b0, t[31:0]};
            hi = t >> 32;
        end
        return r;
    endfunction

    function automatic mib_pkg::fx_t sm_add(input mib_pkg::fx_t a, input mib_pkg::fx_t b);
        mib_pkg::fx_t r;
        r.neg = 1'b0;
        r.mag = '0;
        if (a.neg == b.neg)
        begin
            r.neg = a.neg;
            r.mag = a.mag + b.mag;
        end
        else if (a.mag > b.mag)
        begin
            r.neg = a.neg;
            r.mag = a.mag - b.mag;
        end
        else if (b.mag > a.mag)
        begin
            r.neg = b.neg;
            r.mag = b.mag - a.mag;
        end
        return r;
    endfunction

    function automatic mib_pkg::out_t next_z(input mib_pkg::in_t z);
        mib_pkg::fx_t zr;
        mib_pkg::fx_t zi;
        mib_pkg::fx_t rr;
        mib_pkg::fx_t ii;
        mib_pkg::fx_t two;
        mib_pkg::fx_t re;
        mib_pkg::fx_t im;
        mib_pkg::out_t o;
        zr.neg = z.z_real_negative;
        zr.mag = {z.z_real_high, z.z_real_low};
        zi.neg = z.z_imag_negative;
        zi.mag = {z.z_imag_high, z.z_imag_low};
        two.neg = 1'b0;
        two.mag = 128'd2 << 96;
        rr = mul_trunc(zr, zr);
        ii = mul_trunc(zi, zi);
        ii.neg = 1'b1;
        re = sm_add(sm_add(rr, ii), c_real);
        im = sm_add(mul_trunc(mul_trunc(zr, zi), two), c_imag);
        o.next_real_negative = re.neg;
        {o.next_real_high, o.next_real_low} = re.mag;
        o.next_imag_negative = im.neg;
        {o.next_imag_high, o.next_imag_low} = im.mag;
        return o;
    endfunction

    task automatic report(input string field, input logic [mib_pkg::HALF_W-1:0] got,
                          input logic [mib_pkg::HALF_W-1:0] want);
        $display("mismatch %s: got %h expected %h", field, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        mib_pkg::out_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (next_z_q.size() == 0)
                report("unexpected transfer", out_data.next_real_high, '0);
            else
            begin
                w = next_z_q.pop_front();
                if (out_data.next_real_negative !== w.next_real_negative)
                    report("real sign", 64'(out_data.next_real_negative),
                           64'(w.next_real_negative));
                if (out_data.next_real_high !== w.next_real_high)
                    report("real high", out_data.next_real_high, w.next_real_high);
                if (out_data.next_real_low !== w.next_real_low)
                    report("real low", out_data.next_real_low, w.next_real_low);
                if (out_data.next_imag_negative !== w.next_imag_negative)
                    report("imag sign", 64'(out_data.next_imag_negative),
                           64'(w.next_imag_negative));
                if (out_data.next_imag_high !== w.next_imag_high)
                    report("imag high", out_data.next_imag_high, w.next_imag_high);
                if (out_data.next_imag_low !== w.next_imag_low)
                    report("imag low", out_data.next_imag_low, w.next_imag_low);
            end
        end
    end

    // receiver stall pattern, with long hold-offs on request
    always @(negedge clk)
    begin
        if (holds_seen != hold_reqs)
        begin
            holds_seen = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            case ((cycles / 300) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ((cycles % 7) < 2);
                default: out_stall <= ($urandom_range(0, 99) < 60);
            endcase
        end
    end

    task automatic write_c(input mib_pkg::fx_t re, input mib_pkg::fx_t im);
        logic [mib_pkg::HALF_W-1:0] vals[6];
        logic [mib_pkg::CFG_IDX_W-1:0] idx[6];
        idx = '{mib_pkg::CFG_C_REAL_NEGATIVE, mib_pkg::CFG_C_REAL_HIGH, mib_pkg::CFG_C_REAL_LOW,
                mib_pkg::CFG_C_IMAG_NEGATIVE, mib_pkg::CFG_C_IMAG_HIGH, mib_pkg::CFG_C_IMAG_LOW};
        vals = '{64'(re.neg), re.mag[127:64], re.mag[63:0],
                 64'(im.neg), im.mag[127:64], im.mag[63:0]};
        for (int i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        c_real = re;
        c_imag = im;
    endtask

    task automatic send_z(input mib_pkg::in_t z, input bit known, input mib_pkg::out_t res);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= z;
        do
            @(posedge clk);
        while (in_stall);
        next_z_q.push_back(known ? res : next_z(z));
        burst_left--;
        if (burst_left <= 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (next_z_q.size() != 0)
            @(posedge clk);
        repeat (2 * mib_pkg::STAGES) @(posedge clk);
    endtask

    function automatic logic [mib_pkg::HALF_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic mib_pkg::fx_t rand_fx(input int mode);
        mib_pkg::fx_t f;
        f.neg = 1'($urandom_range(0, 1));
        case (mode)
            0: f.mag = {rand64(), rand64()};
            1: f.mag = {32'($urandom_range(0, 3)), 32'($urandom), rand64()};
            2: f.mag = $urandom_range(0, 1) ? '1 : '0;
            default: f.mag = {32'd0, 32'($urandom_range(0, 1)) << 31, rand64()} >>
                             $urandom_range(0, 90);
        endcase
        return f;
    endfunction

    function automatic mib_pkg::in_t pack_z(input mib_pkg::fx_t zr, input mib_pkg::fx_t zi);
        mib_pkg::in_t z;
        z.z_real_negative = zr.neg;
        {z.z_real_high, z.z_real_low} = zr.mag;
        z.z_imag_negative = zi.neg;
        {z.z_imag_high, z.z_imag_low} = zi.mag;
        return z;
    endfunction

    function automatic mib_pkg::fx_t mk(input bit neg, input logic [mib_pkg::MAG_W-1:0] mag);
        mib_pkg::fx_t f;
        f.neg = neg;
        f.mag = mag;
        return f;
    endfunction

    initial
    begin
        row_t r;
        mib_pkg::out_t none;
        mib_pkg::fx_t one;
        int mode;
        errors = 0;
        cycles = 0;
        hold_reqs = 0;
        holds_seen = 0;
        hold_left = 0;
        burst_left = 10;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mib_pkg::CFG_C_REAL_NEGATIVE;
        cfg_data = '0;
        c_real = '0;
        c_imag = '0;
        one = mk(1'b0, 128'd1 << 96);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // zero Z and C after reset give zero
        r.z = '0; r.known = 1'b1; r.res = '0; dir_rows.push_back(r);
        // negative zeros cancel to plus zero
        r.z = pack_z(mk(1'b1, '0), mk(1'b1, '0)); r.known = 1'b1; r.res = '0;
        dir_rows.push_back(r);
        // real one squared
        r.z = pack_z(one, mk(1'b0, '0)); r.known = 1'b1; r.res = '0;
        r.res.next_real_high = 64'h1_0000_0000; dir_rows.push_back(r);
        r.z = pack_z(mk(1'b1, 128'd1 << 96), mk(1'b1, 128'd1 << 96)); r.known = 1'b0;
        dir_rows.push_back(r);
        r.z = pack_z(mk(1'b0, '1), mk(1'b0, '1)); dir_rows.push_back(r);
        r.z = pack_z(mk(1'b1, '1), mk(1'b0, '1)); dir_rows.push_back(r);
        r.z = pack_z(mk(1'b0, '1), mk(1'b1, '0)); dir_rows.push_back(r);
        r.z = pack_z(mk(1'b0, '0), mk(1'b1, '1)); dir_rows.push_back(r);
        r.z = pack_z(mk(1'b0, 128'd1), mk(1'b1, 128'd1)); dir_rows.push_back(r);
        r.z = pack_z(mk(1'b0, 128'h0000_0001_8000_0000_0000_0000_0000_0000),
                     mk(1'b1, 128'h0000_0001_8000_0000_0000_0000_0000_0000));
        dir_rows.push_back(r);
        r.z = pack_z(mk(1'b1, 128'h8000_0000_0000_0000_0000_0000_0000_0000),
                     mk(1'b0, 128'h0000_0000_FFFF_FFFF_FFFF_FFFF_FFFF_FFFF));
        dir_rows.push_back(r);
        r.z = pack_z(mk(1'b0, 128'h0000_0002_0000_0000_0000_0000_0000_0001),
                     mk(1'b0, 128'h0000_0000_0000_0001_0000_0000_0000_0000));
        dir_rows.push_back(r);

        foreach (dir_rows[i])
            send_z(dir_rows[i].z, dir_rows[i].known, dir_rows[i].res);
        drain();
        write_c(mk(1'b1, '1), mk(1'b1, '1));
        foreach (dir_rows[i])
            send_z(dir_rows[i].z, 1'b0, none);
        drain();
        write_c(mk(1'b0, '1), mk(1'b1, '0));
        foreach (dir_rows[i])
            send_z(dir_rows[i].z, 1'b0, none);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_c(rand_fx(1), rand_fx(1));
                1: write_c(rand_fx(0), rand_fx(0));
                2: write_c(mk(1'b0, '0), mk(1'b0, '0));
                3: write_c(rand_fx(3), rand_fx(1));
                default: write_c(rand_fx(2), rand_fx(0));
            endcase
            for (int n = 0; n < 215; n++)
            begin
                if (n == 60 && phase % 2 == 0)
                    hold_reqs++;
                if (n == 150)
                    drain();
                mode = $urandom_range(0, 9);
                mode = (mode < 5) ? 1 : (mode < 7) ? 0 : (mode < 8) ? 2 : 3;
                send_z(pack_z(rand_fx(mode), rand_fx(mode)), 1'b0, none);
            end
            drain();
        end

        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
